FILE: sv/dffp_pkg.sv
`timescale 1ns / 1ps

package dffp_pkg;

	// Fixed field widths of the channels and the configuration register.
	localparam int COEF_WIDTH = 18;
	localparam int SAMPLE_W   = 16;
	localparam int TAP_IDX_W  = 7;
	localparam int DECIM_W    = 4;

	localparam logic [DECIM_W-1:0] DECIM_RESET = 4'd3;

	localparam logic signed [SAMPLE_W-1:0] PCM_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] PCM_MIN = -16'sh8000;

	// Item function codes.
	localparam logic FUNC_COEF   = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RUN,
		ST_WAIT
	} ctrl_state_t;

	// Sequencer to multiply-accumulate unit, aligned with the memory read data.
	typedef struct packed {
		logic start;
		logic tap_valid;
		logic tap_last;
	} mac_ctl_t;

	// Finished output sample held by the multiply-accumulate unit.
	typedef struct packed {
		logic                       valid;
		logic signed [SAMPLE_W-1:0] pcm;
		logic                       clip;
	} mac_res_t;

endpackage

FILE: sv/dffp_item_if.sv
`timescale 1ns / 1ps

interface dffp_item_if;
	import dffp_pkg::*;

	logic                         valid;
	logic                         ready;
	logic                         func;
	logic [TAP_IDX_W-1:0]         tap_index;
	logic signed [COEF_WIDTH-1:0] tap_value;
	logic signed [SAMPLE_W-1:0]   sample;

	modport source (output valid, output func, output tap_index, output tap_value,
		output sample, input ready);
	modport sink (input valid, input func, input tap_index, input tap_value,
		input sample, output ready);
endinterface

FILE: sv/dffp_result_if.sv
`timescale 1ns / 1ps

interface dffp_result_if;
	import dffp_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] pcm_sample;
	logic                       last_of_frame;
	logic                       clipped;

	modport source (output valid, output pcm_sample, output last_of_frame,
		output clipped, input ready);
	modport sink (input valid, input pcm_sample, input last_of_frame,
		input clipped, output ready);
endinterface

FILE: sv/dffp_mac.sv
`timescale 1ns / 1ps

module dffp_mac #(
	parameter int ACC_W = 45
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  dffp_pkg::mac_ctl_t                            ctl,
	input  logic signed [dffp_pkg::COEF_WIDTH-1:0]        coef_rd,
	input  logic signed [dffp_pkg::SAMPLE_W-1:0]          hist_rd,
	input  logic                                          take,
	output dffp_pkg::mac_res_t                            res
);
	import dffp_pkg::*;

	localparam int PROD_W = COEF_WIDTH + SAMPLE_W;

	logic signed [PROD_W-1:0] prod_s2;
	logic                     v_s2;
	logic                     last_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     pend_q;
	logic signed [ACC_W-1:0]  rnd;
	logic signed [ACC_W-1:0]  y;

	always_ff @(posedge clk) begin
		prod_s2 <= coef_rd * hist_rd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			last_s2 <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			v_s2    <= ctl.tap_valid;
			last_s2 <= ctl.tap_valid & ctl.tap_last;
			if (v_s2 && last_s2) begin
				pend_q <= 1'b1;
			end else if (take) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// Round half up, then an arithmetic shift down to Q1.15.
	always_comb begin
		rnd = acc_q + (ACC_W'(1) <<< (COEF_WIDTH - 2));
		y   = rnd >>> (COEF_WIDTH - 1);
		res.valid = pend_q;
		res.clip  = 1'b0;
		if (y > ACC_W'(PCM_MAX)) begin
			res.pcm  = PCM_MAX;
			res.clip = 1'b1;
		end else if (y < ACC_W'(PCM_MIN)) begin
			res.pcm  = PCM_MIN;
			res.clip = 1'b1;
		end else begin
			res.pcm = y[SAMPLE_W-1:0];
		end
	end

`ifndef ASSERT_OFF
	a_take_pending: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> pend_q)
		else $error("result taken while none pending");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !v_s2)
		else $error("accumulation while a result is pending");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> !v_s2 && !pend_q)
		else $error("accumulator cleared while busy");
`endif

endmodule

FILE: sv/dffp_ctrl.sv
`timescale 1ns / 1ps

module dffp_ctrl #(
	parameter int HISTORY_DEPTH  = 128,
	parameter int TAPS_PER_PHASE = 16,
	parameter int MAX_DECIM      = 8
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	dffp_item_if.sink                              item,
	input  logic [dffp_pkg::DECIM_W-1:0]           decim,
	input  logic                                   take,
	output dffp_pkg::mac_ctl_t                     ctl,
	output logic signed [dffp_pkg::COEF_WIDTH-1:0] coef_rd,
	output logic signed [dffp_pkg::SAMPLE_W-1:0]   hist_rd
);
	import dffp_pkg::*;

	localparam int COEF_DEPTH = MAX_DECIM * TAPS_PER_PHASE;
	localparam int HAW = $clog2(HISTORY_DEPTH);
	localparam int CAW = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
	localparam int CLR_DEPTH = (HISTORY_DEPTH > COEF_DEPTH) ? HISTORY_DEPTH : COEF_DEPTH;
	localparam int CLW = $clog2(CLR_DEPTH + 1);
	localparam int LW  = CLW;
	localparam int MW  = $clog2(MAX_DECIM + 1);
	localparam int PW  = (MAX_DECIM > 1) ? $clog2(MAX_DECIM) : 1;
	localparam int DW2 = (MW > DECIM_W) ? MW : DECIM_W;
	localparam int CIW = $clog2(COEF_DEPTH + 1);
	localparam int IW  = (CIW > TAP_IDX_W) ? CIW : TAP_IDX_W;

	logic signed [SAMPLE_W-1:0]   hist_mem [HISTORY_DEPTH];
	logic signed [COEF_WIDTH-1:0] coef_mem [COEF_DEPTH];

	ctrl_state_t state_q, state_nxt;

	logic [CLW-1:0] clr_q;
	logic [HAW-1:0] wp_q;
	logic [HAW-1:0] rp_q;
	logic [PW-1:0]  phase_q;
	logic [LW-1:0]  k_q;
	logic [LW-1:0]  len_q;
	logic           tap_valid_s1;
	logic           tap_last_s1;

	logic                 accept;
	logic                 clr_last;
	logic [HAW-1:0]       wp_nxt;
	logic [HAW-1:0]       rd_ptr;
	logic [DW2-1:0]       decim_ext;
	logic [MW-1:0]        m;
	logic [MW-1:0]        phase_inc;
	logic                 fire;
	logic [LW-1:0]        len_full;
	logic [LW-1:0]        len_cap;
	logic [IW-1:0]        idx_ext;
	logic                 issue;
	logic                 issue_last;

	logic                         hist_we, coef_we;
	logic [HAW-1:0]               hist_wa;
	logic [CAW-1:0]               coef_wa;
	logic signed [SAMPLE_W-1:0]   hist_wd;
	logic signed [COEF_WIDTH-1:0] coef_wd;

	always_comb begin
		accept    = item.valid && item.ready;
		clr_last  = (clr_q == CLW'(CLR_DEPTH - 1));
		wp_nxt    = (wp_q == HAW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + HAW'(1);
		rd_ptr    = (rp_q == '0) ? HAW'(HISTORY_DEPTH - 1) : rp_q - HAW'(1);
		decim_ext = DW2'(decim);
		if (decim_ext == '0) begin
			m = MW'(1);
		end else if (decim_ext > DW2'(MAX_DECIM)) begin
			m = MW'(MAX_DECIM);
		end else begin
			m = MW'(decim_ext);
		end
		phase_inc = MW'(phase_q) + MW'(1);
		fire      = (phase_inc >= m);
		len_full  = LW'(m) * LW'(TAPS_PER_PHASE);
		len_cap   = (len_full > LW'(HISTORY_DEPTH)) ? LW'(HISTORY_DEPTH) : len_full;
		idx_ext   = IW'(item.tap_index);
		issue_last = (k_q == len_q - LW'(1));
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept && item.func == FUNC_SAMPLE && fire) begin
					state_nxt = ST_RUN;
				end
			end
			ST_RUN: begin
				if (issue_last) begin
					state_nxt = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (take) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_CLEAR;
		endcase
	end

	// Outputs of the sequencer and memory write ports.
	always_comb begin
		item.ready = 1'b0;
		issue      = 1'b0;
		ctl.start  = 1'b0;
		hist_we    = 1'b0;
		coef_we    = 1'b0;
		hist_wa    = wp_q;
		coef_wa    = idx_ext[CAW-1:0];
		hist_wd    = item.sample;
		coef_wd    = item.tap_value;
		unique case (state_q)
			ST_CLEAR: begin
				hist_we = (clr_q < CLW'(HISTORY_DEPTH));
				coef_we = (clr_q < CLW'(COEF_DEPTH));
				hist_wa = clr_q[HAW-1:0];
				coef_wa = clr_q[CAW-1:0];
				hist_wd = '0;
				coef_wd = '0;
			end
			ST_IDLE: begin
				item.ready = 1'b1;
				if (accept) begin
					if (item.func == FUNC_SAMPLE) begin
						hist_we   = 1'b1;
						ctl.start = fire;
					end else begin
						coef_we = (idx_ext < IW'(COEF_DEPTH));
					end
				end
			end
			ST_RUN: begin
				issue = 1'b1;
			end
			ST_WAIT: begin
			end
			default: begin
			end
		endcase
		ctl.tap_valid = tap_valid_s1;
		ctl.tap_last  = tap_last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			wp_q         <= '0;
			rp_q         <= '0;
			phase_q      <= '0;
			k_q          <= '0;
			len_q        <= '0;
			tap_valid_s1 <= 1'b0;
			tap_last_s1  <= 1'b0;
		end else begin
			state_q      <= state_nxt;
			tap_valid_s1 <= issue;
			tap_last_s1  <= issue && issue_last;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + CLW'(1);
			end
			if (accept && item.func == FUNC_SAMPLE) begin
				wp_q <= wp_nxt;
				if (fire) begin
					phase_q <= '0;
					len_q   <= len_cap;
					k_q     <= '0;
					rp_q    <= wp_nxt;
				end else begin
					phase_q <= PW'(phase_inc);
				end
			end
			if (issue) begin
				k_q  <= k_q + LW'(1);
				rp_q <= rd_ptr;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[hist_wa] <= hist_wd;
		end
		hist_rd <= hist_mem[rd_ptr];
	end

	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[coef_wa] <= coef_wd;
		end
		coef_rd <= coef_mem[k_q[CAW-1:0]];
	end

`ifndef ASSERT_OFF
	a_tap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> k_q < len_q)
		else $error("tap counter past filter length");
	a_phase_bound: assert property (@(posedge clk) disable iff (!arst_n)
		MW'(phase_q) < MW'(MAX_DECIM))
		else $error("phase counter out of range");
	a_run_follows_fire: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |=> state_q == ST_RUN && k_q == '0)
		else $error("filter run did not start after a decimation instant");
`endif

endmodule

FILE: sv/decimating_fir_frame_packer.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake        Payload
// item     in         valid / ready    func, tap_index, tap_value, sample
// result   out        valid / ready    pcm_sample, last_of_frame, clipped
// cfg      in         cfg_we only      cfg_wdata = decim_factor
//
// Coefficient writes and non-decimating samples are taken while idle; a decimation instant
// accepts the sample, issues one tap per cycle with the taps capped at the history depth, then
// waits for its result to reach the output register before the next item is taken.
// After reset both memories are swept to zero, one entry per cycle, over
// max(HISTORY_DEPTH, MAX_DECIM*TAPS_PER_PHASE) addresses; items wait during the sweep.
// A stalled result sits in the output register while the next items are taken.
module decimating_fir_frame_packer #(
	parameter int HISTORY_DEPTH  = 128,
	parameter int TAPS_PER_PHASE = 16,
	parameter int MAX_DECIM      = 8,
	parameter int FRAME_SAMPLES  = 160
) (
	input  logic                           clk,
	input  logic                           arst_n,
	dffp_item_if.sink                      item,
	dffp_result_if.source                  result,
	input  logic                           cfg_we,
	input  logic [dffp_pkg::DECIM_W-1:0]   cfg_wdata
);
	import dffp_pkg::*;

	localparam int COEF_DEPTH = MAX_DECIM * TAPS_PER_PHASE;
	// Exact accumulator: full product width plus growth over all taps, plus a
	// guard bit for the rounding offset.
	localparam int ACC_W = COEF_WIDTH + SAMPLE_W + $clog2(COEF_DEPTH + 1) + 1;
	localparam int FW = $clog2(FRAME_SAMPLES + 1);

	logic [DECIM_W-1:0]         decim_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] pcm_q;
	logic                       last_q;
	logic                       clip_q;
	logic [FW-1:0]              frame_q;

	mac_ctl_t                     ctl;
	mac_res_t                     res;
	logic signed [COEF_WIDTH-1:0] coef_rd;
	logic signed [SAMPLE_W-1:0]   hist_rd;
	logic                         take;
	logic [FW-1:0]                frame_inc;
	logic                         frame_end;

	// The sequencer owns the sample history and coefficient memories and walks
	// the taps, newest sample first.
	dffp_ctrl #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.TAPS_PER_PHASE(TAPS_PER_PHASE),
		.MAX_DECIM     (MAX_DECIM)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.decim  (decim_q),
		.take   (take),
		.ctl    (ctl),
		.coef_rd(coef_rd),
		.hist_rd(hist_rd)
	);

	// Multiply, accumulate, round and saturate.
	dffp_mac #(
		.ACC_W(ACC_W)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.coef_rd(coef_rd),
		.hist_rd(hist_rd),
		.take   (take),
		.res    (res)
	);

	// A finished sample moves into the output register as soon as that register
	// is free or is being emptied by a transaction in the same cycle.
	always_comb begin
		take      = res.valid && (!out_valid_q || result.ready);
		frame_inc = frame_q + FW'(1);
		frame_end = (frame_inc >= FW'(FRAME_SAMPLES));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decim_q     <= DECIM_RESET;
			out_valid_q <= 1'b0;
			frame_q     <= '0;
		end else begin
			if (cfg_we) begin
				decim_q <= cfg_wdata;
			end
			if (take) begin
				out_valid_q <= 1'b1;
				frame_q     <= frame_end ? '0 : frame_inc;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pcm_q  <= res.pcm;
			clip_q <= res.clip;
			last_q <= frame_end;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.pcm_sample    = pcm_q;
	assign result.last_of_frame = last_q;
	assign result.clipped       = clip_q;

`ifndef ASSERT_OFF
	a_frame_range: assert property (@(posedge clk) disable iff (!arst_n)
		frame_q < FW'(FRAME_SAMPLES))
		else $error("frame position out of range");
	a_take_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> !res.valid)
		else $error("result still pending after hand-off");
	a_no_accept_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |-> !res.valid)
		else $error("item accepted while a result waits for the output register");
	a_hold_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !take) |=> res.valid && $stable(res.pcm))
		else $error("pending result lost or changed");
`endif

endmodule
